[src/itbac_pkg.sv]
// Package for the IR touch button with automatic calibration.
// Holds the shared types, register indexes, reset values and FSM states.
// No dependencies; every other file of the block uses it.
`default_nettype none

package itbac_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int MAX_AVERAGE_DEF = 64;

    localparam int IR_W       = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_INTERVAL = 3'd0,
        REG_DELTA_LIMIT     = 3'd1,
        REG_SAMPLES_PER_AVG = 3'd2,
        REG_PRESS_SENS      = 3'd3,
        REG_PRESS_HIT_LIMIT = 3'd4,
        REG_HIT_GAP_RESET   = 3'd5,
        REG_RELEASE_TIMEOUT = 3'd6
    } cfg_index_t;

    localparam logic [15:0] RST_SAMPLE_INTERVAL = 16'd10;
    localparam logic [9:0]  RST_DELTA_LIMIT     = 10'd20;
    localparam logic [6:0]  RST_SAMPLES_PER_AVG = 7'd10;
    localparam logic [9:0]  RST_PRESS_SENS      = 10'd50;
    localparam logic [7:0]  RST_PRESS_HIT_LIMIT = 8'd3;
    localparam logic [15:0] RST_HIT_GAP_RESET   = 16'd500;
    localparam logic [15:0] RST_RELEASE_TIMEOUT = 16'd100;

    typedef struct packed {
        logic [15:0] sample_interval_ms;
        logic [9:0]  delta_limit;
        logic [6:0]  samples_per_average;
        logic [9:0]  level_margin;
        logic [7:0]  press_hit_limit;
        logic [15:0] hit_gap_reset_ms;
        logic [15:0] release_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0]     now_ms;
        logic [IR_W-1:0] ir_sample;
    } in_t;

    typedef struct packed {
        logic        pressed;
        logic [1:0]  press_events;
        logic        release_events;
        logic        calibrated;
        logic [9:0]  ir_level;
        logic [10:0] press_threshold;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAKE,
        ST_CHECK1,
        ST_ACC,
        ST_DIV,
        ST_AVG,
        ST_CHECK2,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic take;
        logic check;
        logic accum;
        logic div_load;
        logic div_step;
        logic div_finish;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic take_ok;
        logic accum_ok;
        logic avg_due;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[src/itbac_cfg.sv]
// Configuration register file of the IR touch button.
// Depends on itbac_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module itbac_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [itbac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [itbac_pkg::CFG_DATA_W-1:0] cfg_data,
    output itbac_pkg::cfg_t                       cfg
);

    itbac_pkg::cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                itbac_pkg::REG_SAMPLE_INTERVAL: cfg_next.sample_interval_ms  = cfg_data;
                itbac_pkg::REG_DELTA_LIMIT:     cfg_next.delta_limit         = cfg_data[9:0];
                itbac_pkg::REG_SAMPLES_PER_AVG: cfg_next.samples_per_average = cfg_data[6:0];
                itbac_pkg::REG_PRESS_SENS:      cfg_next.level_margin        = cfg_data[9:0];
                itbac_pkg::REG_PRESS_HIT_LIMIT: cfg_next.press_hit_limit     = cfg_data[7:0];
                itbac_pkg::REG_HIT_GAP_RESET:   cfg_next.hit_gap_reset_ms    = cfg_data;
                itbac_pkg::REG_RELEASE_TIMEOUT: cfg_next.release_timeout_ms  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_interval_ms  <= itbac_pkg::RST_SAMPLE_INTERVAL;
            cfg_reg.delta_limit         <= itbac_pkg::RST_DELTA_LIMIT;
            cfg_reg.samples_per_average <= itbac_pkg::RST_SAMPLES_PER_AVG;
            cfg_reg.level_margin        <= itbac_pkg::RST_PRESS_SENS;
            cfg_reg.press_hit_limit     <= itbac_pkg::RST_PRESS_HIT_LIMIT;
            cfg_reg.hit_gap_reset_ms    <= itbac_pkg::RST_HIT_GAP_RESET;
            cfg_reg.release_timeout_ms  <= itbac_pkg::RST_RELEASE_TIMEOUT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[src/itbac_ctrl.sv]
// Sequencing state machine of the IR touch button.
// Depends on itbac_pkg for state_t, cmd_t and status_t.
`default_nettype none

module itbac_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire itbac_pkg::status_t st,
    output itbac_pkg::cmd_t         cmd
);

    itbac_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            itbac_pkg::ST_IDLE:   if (s_valid) state_next = itbac_pkg::ST_TAKE;
            itbac_pkg::ST_TAKE:   state_next = st.take_ok ? itbac_pkg::ST_CHECK1
                                                          : itbac_pkg::ST_CHECK2;
            itbac_pkg::ST_CHECK1: state_next = itbac_pkg::ST_ACC;
            itbac_pkg::ST_ACC:    state_next = (st.accum_ok && st.avg_due) ? itbac_pkg::ST_DIV
                                                                           : itbac_pkg::ST_CHECK2;
            itbac_pkg::ST_DIV:    if (st.div_last) state_next = itbac_pkg::ST_AVG;
            itbac_pkg::ST_AVG:    state_next = itbac_pkg::ST_CHECK2;
            itbac_pkg::ST_CHECK2: state_next = itbac_pkg::ST_OUT;
            itbac_pkg::ST_OUT:    if (st.out_free) state_next = itbac_pkg::ST_IDLE;
            default:              state_next = itbac_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            itbac_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            itbac_pkg::ST_TAKE:   cmd.take = 1'b1;
            itbac_pkg::ST_CHECK1: cmd.check = 1'b1;
            itbac_pkg::ST_ACC: begin
                cmd.accum    = 1'b1;
                cmd.div_load = st.accum_ok && st.avg_due;
            end
            itbac_pkg::ST_DIV:    cmd.div_step = 1'b1;
            itbac_pkg::ST_AVG:    cmd.div_finish = 1'b1;
            itbac_pkg::ST_CHECK2: cmd.check = 1'b1;
            itbac_pkg::ST_OUT:    cmd.out_load = st.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= itbac_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[src/itbac_dpath.sv]
// Datapath of the IR touch button: sample registers, press check, running sum,
// restoring divider for the average and the output register.
// Depends on itbac_pkg; driven by commands from itbac_ctrl.
`default_nettype none

module itbac_dpath #(
    parameter int SAMPLE_BITS = itbac_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_AVERAGE = itbac_pkg::MAX_AVERAGE_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire itbac_pkg::cfg_t    cfg,
    input  wire itbac_pkg::cmd_t    cmd,
    output itbac_pkg::status_t      st,
    input  wire itbac_pkg::in_t     s_data,
    input  wire logic               m_ready,
    output logic                    m_valid,
    output itbac_pkg::out_t         m_data
);

    localparam int RAW_W  = (SAMPLE_BITS < itbac_pkg::IR_W) ? SAMPLE_BITS : itbac_pkg::IR_W;
    localparam int SUM_W  = RAW_W + $clog2(MAX_AVERAGE);
    localparam int AVG_W  = (SUM_W > 10) ? SUM_W : 10;
    localparam int THR_W  = AVG_W + 1;
    localparam int CNT_W  = $clog2(MAX_AVERAGE + 1);
    localparam int DCNT_W = $clog2(SUM_W + 1);

    logic [31:0]       now_reg;
    logic [RAW_W-1:0]  raw_reg;

    logic [RAW_W-1:0]  latest_reg, latest_next;
    logic [RAW_W-1:0]  prior_reg, prior_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [AVG_W-1:0]  avg_reg, avg_next;
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic              cal_reg, cal_next;
    logic [31:0]       lst_reg, lst_next;
    logic              pa_reg, pa_next;
    logic [7:0]        hc_reg, hc_next;
    logic [31:0]       lht_reg, lht_next;
    logic [1:0]        evp_reg, evp_next;
    logic              evr_reg, evr_next;
    logic              ov_reg, ov_next;

    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;

    logic              hit, gap_clr, press_set, pa_mid, rel_now;
    logic [31:0]       hit_diff, rel_diff;
    logic [8:0]        hc_inc;
    logic [7:0]        hc_chk;
    logic [31:0]       lht_chk;

    logic [8:0]        spa_w, size_w;
    logic [CNT_W-1:0]  avg_size;
    logic [RAW_W-1:0]  delta;
    logic [SUM_W-1:0]  sum_acc;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W:0]    trial;
    logic              trial_ge;

    // Press check, shared by the sample path and the per-tick check.
    always_comb begin
        hit       = THR_W'(latest_reg) > thr_reg;
        hit_diff  = now_reg - lht_reg;
        gap_clr   = (hit_diff >= 32'(cfg.hit_gap_reset_ms)) && (lht_reg != 32'd0);
        hc_inc    = (gap_clr ? 9'd0 : {1'b0, hc_reg}) + 9'd1;
        press_set = hit && !pa_reg && (hc_inc > {1'b0, cfg.press_hit_limit});
        pa_mid    = pa_reg || press_set;
        hc_chk    = hc_reg;
        if (hit && !pa_reg) begin
            hc_chk = press_set ? 8'd0 : hc_inc[7:0];
        end
        rel_diff  = hit ? 32'd0 : hit_diff;
        rel_now   = pa_mid && (rel_diff >= 32'(cfg.release_timeout_ms));
        lht_chk   = rel_now ? 32'd0 : (hit ? now_reg : lht_reg);
    end

    always_comb begin
        spa_w = 9'(cfg.samples_per_average);
        if (spa_w == 9'd0) begin
            size_w = 9'd1;
        end else if (spa_w > 9'(MAX_AVERAGE)) begin
            size_w = 9'(MAX_AVERAGE);
        end else begin
            size_w = spa_w;
        end
        avg_size = CNT_W'(size_w);
        delta    = (prior_reg > latest_reg) ? (prior_reg - latest_reg)
                                            : (latest_reg - prior_reg);
        sum_acc  = sum_reg + SUM_W'(latest_reg);
        cnt_inc  = cnt_reg + CNT_W'(1);
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        trial_ge = trial >= {1'b0, avg_size};
    end

    always_comb begin
        st.take_ok  = (now_reg - lst_reg) >= 32'(cfg.sample_interval_ms);
        st.accum_ok = !(pa_reg && (thr_reg != '0)) && (10'(delta) < cfg.delta_limit);
        st.avg_due  = cnt_inc >= avg_size;
        st.div_last = dcnt_reg == DCNT_W'(1);
        st.out_free = !ov_reg || m_ready;
    end

    always_comb begin
        latest_next = latest_reg;
        prior_next  = prior_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        avg_next    = avg_reg;
        thr_next    = thr_reg;
        cal_next    = cal_reg;
        lst_next    = lst_reg;
        pa_next     = pa_reg;
        hc_next     = hc_reg;
        lht_next    = lht_reg;
        evp_next    = evp_reg;
        evr_next    = evr_reg;
        ov_next     = ov_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dcnt_next   = dcnt_reg;

        if (cmd.load_in) begin
            evp_next = 2'd0;
            evr_next = 1'b0;
        end
        if (cmd.take && st.take_ok) begin
            prior_next  = latest_reg;
            latest_next = raw_reg;
        end
        if (cmd.check) begin
            pa_next  = pa_mid && !rel_now;
            hc_next  = hc_chk;
            lht_next = lht_chk;
            if (hit && pa_mid && (evp_reg != 2'd3)) begin
                evp_next = evp_reg + 2'd1;
            end
            if (rel_now) begin
                evr_next = 1'b1;
            end
        end
        if (cmd.accum && st.accum_ok) begin
            sum_next = sum_acc;
            cnt_next = cnt_inc;
            if (!st.avg_due) begin
                lst_next = now_reg;
            end
        end
        if (cmd.div_load) begin
            rem_next  = '0;
            quo_next  = sum_acc;
            dcnt_next = DCNT_W'(SUM_W);
        end
        if (cmd.div_step) begin
            rem_next  = trial_ge ? CNT_W'(trial - {1'b0, avg_size}) : trial[CNT_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], trial_ge};
            dcnt_next = dcnt_reg - DCNT_W'(1);
        end
        if (cmd.div_finish) begin
            avg_next = AVG_W'(quo_reg);
            thr_next = THR_W'(quo_reg) + THR_W'(cfg.level_margin);
            sum_next = '0;
            cnt_next = '0;
            cal_next = 1'b1;
            lst_next = now_reg;
        end
        if (cmd.out_load) begin
            ov_next = 1'b1;
        end else if (m_ready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latest_reg <= '0;
            prior_reg  <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            avg_reg    <= '0;
            thr_reg    <= '0;
            cal_reg    <= 1'b0;
            lst_reg    <= '0;
            pa_reg     <= 1'b0;
            hc_reg     <= '0;
            lht_reg    <= '0;
            evp_reg    <= '0;
            evr_reg    <= 1'b0;
            ov_reg     <= 1'b0;
            dcnt_reg   <= '0;
        end else begin
            latest_reg <= latest_next;
            prior_reg  <= prior_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            avg_reg    <= avg_next;
            thr_reg    <= thr_next;
            cal_reg    <= cal_next;
            lst_reg    <= lst_next;
            pa_reg     <= pa_next;
            hc_reg     <= hc_next;
            lht_reg    <= lht_next;
            evp_reg    <= evp_next;
            evr_reg    <= evr_next;
            ov_reg     <= ov_next;
            dcnt_reg   <= dcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.load_in) begin
            now_reg <= s_data.now_ms;
            raw_reg <= s_data.ir_sample[RAW_W-1:0];
        end
        if (cmd.out_load) begin
            m_data.pressed         <= pa_reg;
            m_data.press_events    <= evp_reg;
            m_data.release_events  <= evr_reg;
            m_data.calibrated      <= cal_reg;
            m_data.ir_level        <= avg_reg[9:0];
            m_data.press_threshold <= thr_reg[10:0];
        end
    end

    assign m_valid = ov_reg;

endmodule

`default_nettype wire

[src/ir_touch_button_autocal.sv]
// Top level of the IR touch button with automatic calibration.
// A tick runs from accept through TAKE, CHECK2 and OUT when no sample is due. A sample that
// is taken adds CHECK1 and ACC after TAKE, and one that closes an average also runs DIV, the
// bit-serial divider (one quotient bit per cycle), and AVG before CHECK2. The result beat is
// loaded in OUT; a stalled output holds the next tick back.
// aresetn (synchronous) restores the registers to their defaults and clears all tracking state.
`default_nettype none

module ir_touch_button_autocal #(
    parameter int SAMPLE_BITS = itbac_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_AVERAGE = itbac_pkg::MAX_AVERAGE_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire itbac_pkg::in_t                   s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output itbac_pkg::out_t                       m_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [itbac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [itbac_pkg::CFG_DATA_W-1:0] cfg_data
);

    itbac_pkg::cfg_t    cfg;
    itbac_pkg::cmd_t    cmd;
    itbac_pkg::status_t st;

    itbac_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    itbac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    itbac_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_AVERAGE (MAX_AVERAGE)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .st      (st),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    // The block works on one tick at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a tick is in progress");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.calibrated |->
            (m_data.press_threshold == 11'd0) && (m_data.ir_level == 10'd0))
        else $error("level or threshold set before calibration");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.press_events != 2'd0) |->
            (m_data.press_events != 2'd3) && (m_data.pressed || m_data.release_events))
        else $error("press beat without a press state");

endmodule

`default_nettype wire

[verif/tb_ir_touch_button_autocal.sv]
`timescale 1ns / 100ps
// Testbench for ir_touch_button_autocal: predicts every tick's button report and checks it.
// Drives ticks and register writes over valid/ready channels with random idling phases.
// Depends on the itbac_pkg package and the ir_touch_button_autocal top level.

module tb_ir_touch_button_autocal;

    localparam int AVERAGE_CAP = 64;
    // Slowest ticks run the divider and can meet random stalls on both sides.
    localparam int CYCLE_LIMIT = 600000;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    itbac_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    itbac_pkg::out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [itbac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [itbac_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    itbac_pkg::cfg_t button_cfg = {16'd10, 10'd20, 7'd10, 10'd50, 8'd3, 16'd500, 16'd100};
    logic [9:0] ir_latest = '0;
    logic [9:0] ir_prior = '0;
    logic [31:0] level_sum = '0;
    int unsigned level_count = 0;
    logic [31:0] level_avg = '0;
    logic [31:0] press_thr = '0;
    logic cal_done = 1'b0;
    logic [31:0] sample_stamp = '0;
    logic button_down = 1'b0;
    logic [7:0] hit_tally = '0;
    logic [31:0] hit_stamp = '0;
    int unsigned press_ev_tick = 0;
    int unsigned release_ev_tick = 0;

    itbac_pkg::out_t button_reports_due[$];
    logic [31:0] clock_ms = '0;
    int mismatches = 0;
    int cycles_run = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    ir_touch_button_autocal dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic press_check(input logic [31:0] now);
        logic hit;
        logic [8:0] next_tally;
        hit = 32'(ir_latest) > press_thr;
        if (hit && !button_down) begin
            if (now - hit_stamp >= 32'(button_cfg.hit_gap_reset_ms) && hit_stamp != 32'd0) begin
                hit_tally = '0;
            end
            next_tally = {1'b0, hit_tally} + 9'd1;
            hit_stamp = now;
            if (next_tally > {1'b0, button_cfg.press_hit_limit}) begin
                button_down = 1'b1;
                hit_tally = '0;
            end else begin
                hit_tally = next_tally[7:0];
            end
        end
        if (hit && button_down) begin
            hit_stamp = now;
            press_ev_tick++;
        end
        if (button_down) begin
            if (now - hit_stamp >= 32'(button_cfg.release_timeout_ms)) begin
                button_down = 1'b0;
                hit_stamp = '0;
                release_ev_tick++;
                return 1'b0;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic itbac_pkg::out_t predict_button_report(input itbac_pkg::in_t beat);
        itbac_pkg::out_t report;
        logic still_down;
        logic [9:0] jump;
        int unsigned span;
        press_ev_tick = 0;
        release_ev_tick = 0;
        if (beat.now_ms - sample_stamp >= 32'(button_cfg.sample_interval_ms)) begin
            ir_prior = ir_latest;
            ir_latest = beat.ir_sample;
            still_down = press_check(beat.now_ms);
            jump = (ir_prior > ir_latest) ? ir_prior - ir_latest : ir_latest - ir_prior;
            if (!(still_down && press_thr != 32'd0) && jump < button_cfg.delta_limit) begin
                span = 32'(button_cfg.samples_per_average);
                if (span == 0) span = 1;
                if (span > AVERAGE_CAP) span = AVERAGE_CAP;
                level_sum += 32'(ir_latest);
                level_count++;
                if (level_count >= span) begin
                    level_avg = level_sum / span;
                    press_thr = level_avg + 32'(button_cfg.level_margin);
                    level_sum = '0;
                    level_count = 0;
                    cal_done = 1'b1;
                end
                sample_stamp = beat.now_ms;
            end
        end
        void'(press_check(beat.now_ms));
        report.pressed = button_down;
        report.press_events = (press_ev_tick > 3) ? 2'd3 : press_ev_tick[1:0];
        report.release_events = (release_ev_tick != 0);
        report.calibrated = cal_done;
        report.ir_level = level_avg[9:0];
        report.press_threshold = press_thr[10:0];
        return report;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        itbac_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (button_reports_due.size() == 0) begin
                $display("%0t ns: unexpected beat, expected none, got %h", $time, m_data);
                mismatches++;
            end else begin
                want = button_reports_due.pop_front();
                compare_field("pressed", 32'(want.pressed), 32'(m_data.pressed));
                compare_field("press_events", 32'(want.press_events),
                              32'(m_data.press_events));
                compare_field("release_events", 32'(want.release_events),
                              32'(m_data.release_events));
                compare_field("calibrated", 32'(want.calibrated), 32'(m_data.calibrated));
                compare_field("ir_level", 32'(want.ir_level), 32'(m_data.ir_level));
                compare_field("press_threshold", 32'(want.press_threshold),
                              32'(m_data.press_threshold));
            end
        end
    end

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        cycles_run++;
        if (cycles_run > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic itbac_pkg::cfg_t make_settings(input int interval, input int delta,
                                                      input int size, input int sens,
                                                      input int hit_limit, input int gap,
                                                      input int release_ms);
        itbac_pkg::cfg_t regs;
        regs.sample_interval_ms = 16'(interval);
        regs.delta_limit = 10'(delta);
        regs.samples_per_average = 7'(size);
        regs.level_margin = 10'(sens);
        regs.press_hit_limit = 8'(hit_limit);
        regs.hit_gap_reset_ms = 16'(gap);
        regs.release_timeout_ms = 16'(release_ms);
        return regs;
    endfunction

    function automatic int pick_setting(input int lo, input int hi, input int usual_hi);
        int roll;
        roll = $urandom_range(7);
        if (roll == 0) return lo;
        if (roll == 1) return hi;
        return $urandom_range(lo, usual_hi);
    endfunction

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    task automatic write_reg(input itbac_pkg::cfg_index_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            itbac_pkg::REG_SAMPLE_INTERVAL: button_cfg.sample_interval_ms = value;
            itbac_pkg::REG_DELTA_LIMIT:     button_cfg.delta_limit = value[9:0];
            itbac_pkg::REG_SAMPLES_PER_AVG: button_cfg.samples_per_average = value[6:0];
            itbac_pkg::REG_PRESS_SENS:      button_cfg.level_margin = value[9:0];
            itbac_pkg::REG_PRESS_HIT_LIMIT: button_cfg.press_hit_limit = value[7:0];
            itbac_pkg::REG_HIT_GAP_RESET:   button_cfg.hit_gap_reset_ms = value;
            itbac_pkg::REG_RELEASE_TIMEOUT: button_cfg.release_timeout_ms = value;
            default: ;
        endcase
    endtask

    task automatic configure(input itbac_pkg::cfg_t regs);
        write_reg(itbac_pkg::REG_SAMPLE_INTERVAL, regs.sample_interval_ms);
        write_reg(itbac_pkg::REG_DELTA_LIMIT, 16'(regs.delta_limit));
        write_reg(itbac_pkg::REG_SAMPLES_PER_AVG, 16'(regs.samples_per_average));
        write_reg(itbac_pkg::REG_PRESS_SENS, 16'(regs.level_margin));
        write_reg(itbac_pkg::REG_PRESS_HIT_LIMIT, 16'(regs.press_hit_limit));
        write_reg(itbac_pkg::REG_HIT_GAP_RESET, regs.hit_gap_reset_ms);
        write_reg(itbac_pkg::REG_RELEASE_TIMEOUT, regs.release_timeout_ms);
        cfg_valid <= 1'b0;
    endtask

    // Valid stays high after a beat; the next call either reloads it or drops it.
    task automatic send_tick(input logic [31:0] now, input logic [9:0] raw);
        itbac_pkg::in_t beat;
        beat.now_ms = now;
        beat.ir_sample = raw;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        button_reports_due.push_back(predict_button_report(beat));
    endtask

    task automatic drain_reports();
        s_valid <= 1'b0;
        while (button_reports_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly a steady floor with jitter, broken by bursts of bright readings and noise.
    task automatic run_ticks(input int count, input int step_max);
        int left;
        int kind;
        int base;
        int spread;
        int raw;
        left = 0;
        kind = 0;
        spread = 0;
        base = $urandom_range(40, 700);
        for (int i = 0; i < count; i++) begin
            if (left == 0) begin
                kind = $urandom_range(9);
                left = $urandom_range(2, 30);
                spread = $urandom_range(0, 8);
                if ($urandom_range(3) == 0) base = $urandom_range(0, 1023);
            end
            left--;
            if (kind < 6) raw = base + $urandom_range(0, 2 * spread) - spread;
            else if (kind < 9) raw = $urandom_range(base + (1023 - base) / 2, 1023);
            else raw = $urandom_range(0, 1023);
            if (raw < 0) raw = 0;
            if (raw > 1023) raw = 1023;
            if (kind == 9 || $urandom_range(49) == 0) clock_ms += $urandom();
            else clock_ms += $urandom_range(0, step_max);
            send_tick(clock_ms, raw[9:0]);
        end
    endtask

    task automatic test_reset_values();
        set_idling(0, 0);
        send_tick(32'd0, 10'd0);
        send_tick(32'd10, 10'd1023);
        send_tick(32'd11, 10'd1023);
        send_tick(32'hFFFF_FFFF, 10'd0);
        send_tick(32'h0000_0009, 10'd512);
        send_tick(32'h8000_0000, 10'd341);
        send_tick(32'h7FFF_FFFF, 10'd682);
        drain_reports();
    endtask

    task automatic test_calibration();
        configure(make_settings(5, 30, 3, 40, 1, 50, 20));
        send_tick(32'd1000, 10'd300);
        send_tick(32'd1005, 10'd305);
        send_tick(32'd1010, 10'd310);
        send_tick(32'd1015, 10'd320);
        send_tick(32'd1020, 10'd600);
        send_tick(32'd1025, 10'd600);
        send_tick(32'd1030, 10'd600);
        send_tick(32'd1100, 10'd300);
        send_tick(32'd1105, 10'd301);
        drain_reports();
    endtask

    // Zero average size and zero release timeout: a press can set and release twice per tick.
    task automatic test_corner_settings();
        configure(make_settings(0, 1, 0, 0, 0, 0, 0));
        send_tick(32'd2000, 10'd50);
        send_tick(32'd2001, 10'd50);
        send_tick(32'd2002, 10'd1023);
        send_tick(32'd2003, 10'd1023);
        drain_reports();
    endtask

    task automatic test_default_traffic();
        configure(make_settings(10, 20, 10, 50, 3, 500, 100));
        set_idling(0, 0);
        run_ticks(250, 8);
        drain_reports();
    endtask

    task automatic test_minimum_settings();
        configure(make_settings(0, 1, 1, 0, 0, 0, 1));
        set_idling(50, 0);
        run_ticks(200, 3);
        drain_reports();
    endtask

    task automatic test_maximum_settings();
        clock_ms = 32'hFFFF_0000;
        configure(make_settings(65535, 1023, 64, 1023, 255, 65535, 65535));
        set_idling(0, 50);
        run_ticks(150, 40000);
        drain_reports();
    endtask

    task automatic test_oversized_average();
        configure(make_settings(3, 60, 100, 30, 2, 40, 30));
        set_idling(20, 20);
        run_ticks(250, 6);
        drain_reports();
    endtask

    // Two hits per tick from rejected bright samples drive the hit count past 255.
    task automatic test_hit_limit_ceiling();
        configure(make_settings(0, 10, 1, 0, 255, 65535, 65535));
        set_idling(0, 0);
        clock_ms += 100000;
        send_tick(clock_ms, 10'd200);
        clock_ms += 1;
        send_tick(clock_ms, 10'd200);
        for (int i = 0; i < 150; i++) begin
            clock_ms += 1;
            send_tick(clock_ms, (i % 2 == 0) ? 10'd1023 : 10'd1000);
        end
        for (int i = 0; i < 10; i++) begin
            clock_ms += 1;
            send_tick(clock_ms, 10'd200);
        end
        clock_ms += 65535;
        send_tick(clock_ms, 10'd200);
        for (int i = 0; i < 5; i++) begin
            clock_ms += 1;
            send_tick(clock_ms, 10'd200);
        end
        drain_reports();
    endtask

    task automatic test_random_settings();
        for (int round = 0; round < 3; round++) begin
            configure(make_settings(pick_setting(0, 65535, 30), pick_setting(1, 1023, 80),
                                    pick_setting(0, 127, 16), pick_setting(0, 1023, 100),
                                    pick_setting(0, 255, 6), pick_setting(0, 65535, 600),
                                    pick_setting(0, 65535, 300)));
            case (round)
                0: begin
                    set_idling(50, 0);
                end
                1: begin
                    set_idling(0, 50);
                end
                default: begin
                    set_idling(20, 20);
                end
            endcase
            run_ticks(200, 40);
            drain_reports();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_calibration();
        test_corner_settings();
        test_default_traffic();
        test_minimum_settings();
        test_maximum_settings();
        test_oversized_average();
        test_hit_limit_ceiling();
        test_random_settings();
        repeat (30) @(posedge aclk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
